[design/ntcp_pkg.sv]
// ----------------------------------------------------------------------------
// ntcp_pkg
// Word types, codes and small lookup functions for the note text parser.
// ----------------------------------------------------------------------------
package ntcp_pkg;

   typedef struct packed {
      logic       req_type;
      logic [7:0] ch;
      logic [7:0] query_pos;
   } ntcp_req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] code_byte;
      logic [2:0] error_code;
      logic [8:0] stored_count;
      logic [3:0] duration_sixteenths;
      logic [6:0] midi_pitch;
      logic [7:0] start_pos;
      logic       last;
   } ntcp_rsp_type;

   typedef struct packed {
      logic accept;
      logic char_commit;
      logic second;
      logic q_start;
      logic q_capture;
      logic q_step;
      logic q_load;
   } ntcp_cmd_type;

   typedef struct packed {
      logic       in_query;
      logic [1:0] nres;
      logic       past_end;
      logic       walk_done;
      logic       out_free;
   } ntcp_stat_type;

   localparam logic       REQ_CHAR  = 1'b0;
   localparam logic       REQ_QUERY = 1'b1;

   localparam logic [1:0] KIND_CODE   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;
   localparam logic [1:0] KIND_QUERY  = 2'd3;

   localparam logic [2:0] ERR_BAD_NAME  = 3'd0;
   localparam logic [2:0] ERR_PITCH     = 3'd1;
   localparam logic [2:0] ERR_BAD_DUR   = 3'd2;
   localparam logic [2:0] ERR_TIE_FIRST = 3'd3;
   localparam logic [2:0] ERR_DOT_FIRST = 3'd4;
   localparam logic [2:0] ERR_DOT_SIX   = 3'd5;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd6;
   localparam logic [2:0] ERR_NONE      = 3'd7;

   localparam logic [3:0] PH_START = 4'd0;
   localparam logic [3:0] PH_NAME2 = 4'd1;
   localparam logic [3:0] PH_NAME3 = 4'd2;
   localparam logic [3:0] PH_ACC   = 4'd3;
   localparam logic [3:0] PH_DUR   = 4'd4;
   localparam logic [3:0] PH_TIE   = 4'd5;
   localparam logic [3:0] PH_DONE  = 4'd6;

   localparam logic [2:0] DUR_WHOLE = 3'd4;
   localparam logic [2:0] DUR_BAD   = 3'd7;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_TIE   = 8'h5F;
   localparam logic [7:0] CH_FLAT  = 8'h62;

   localparam logic [7:0] MIDI_OFFSET = 8'd30;

   function automatic logic [7:0] second_char(input logic [2:0] n);
      case (n)
         3'd0:    second_char = 8'h6F;
         3'd1:    second_char = 8'h61;
         3'd2:    second_char = 8'h69;
         3'd3:    second_char = 8'h6F;
         3'd4:    second_char = 8'h65;
         3'd5:    second_char = 8'h69;
         3'd6:    second_char = 8'h61;
         default: second_char = 8'h00;
      endcase
   endfunction

   // pitch base in quarter units, name 0 (sol) through 6 (fa)
   function automatic logic signed [9:0] name_base(input logic [2:0] n);
      case (n)
         3'd0:    name_base = 10'sd4;
         3'd1:    name_base = 10'sd12;
         3'd2:    name_base = 10'sd20;
         3'd3:    name_base = 10'sd24;
         3'd4:    name_base = 10'sd32;
         3'd5:    name_base = 10'sd40;
         3'd6:    name_base = 10'sd44;
         default: name_base = 10'sd0;
      endcase
   endfunction

   function automatic logic [2:0] dur_code(input logic [7:0] c);
      case (c)
         8'h73:   dur_code = 3'd0;
         8'h63:   dur_code = 3'd1;
         8'h6E:   dur_code = 3'd2;
         8'h62:   dur_code = 3'd3;
         8'h72:   dur_code = DUR_WHOLE;
         default: dur_code = DUR_BAD;
      endcase
   endfunction

endpackage

[design/ntcp_ctrl.sv]
// ----------------------------------------------------------------------------
// ntcp_ctrl
// Sequencer: takes a word, commits a character or walks the store for a query.
// ----------------------------------------------------------------------------
module ntcp_ctrl
   import ntcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  ntcp_stat_type stat,
   output ntcp_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHAR   = 3'd1;
   localparam logic [2:0] S_SECOND = 3'd2;
   localparam logic [2:0] S_QRY    = 3'd3;
   localparam logic [2:0] S_QFIRST = 3'd4;
   localparam logic [2:0] S_QWALK  = 3'd5;
   localparam logic [2:0] S_QOUT   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.in_query ? S_QRY : S_CHAR;
            end
         end
         S_CHAR: begin
            if (stat.out_free || stat.nres == 2'd0) begin
               cmd.char_commit = 1'b1;
               state_in        = (stat.nres == 2'd2) ? S_SECOND : S_IDLE;
            end
         end
         S_SECOND: begin
            if (stat.out_free) begin
               cmd.second = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_QRY: begin
            if (stat.past_end) begin
               if (stat.out_free) begin
                  cmd.q_load = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.q_start = 1'b1;
               state_in    = S_QFIRST;
            end
         end
         S_QFIRST: begin
            cmd.q_capture = 1'b1;
            if (stat.walk_done) begin
               state_in = S_QOUT;
            end else begin
               cmd.q_step = 1'b1;
               state_in   = S_QWALK;
            end
         end
         S_QWALK: begin
            if (stat.walk_done) begin
               state_in = S_QOUT;
            end else begin
               cmd.q_step = 1'b1;
            end
         end
         S_QOUT: begin
            if (stat.out_free) begin
               cmd.q_load = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/ntcp_dp.sv]
// ----------------------------------------------------------------------------
// ntcp_dp
// Parser registers, code store, query walk and the result word register.
// ----------------------------------------------------------------------------
module ntcp_dp
   import ntcp_pkg::*;
#(
   parameter int STORE_DEPTH = 256
)
(
   input  logic          clock,
   input  logic          reset,
   input  ntcp_req_type  req_data,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output ntcp_rsp_type  rsp_data,
   input  ntcp_cmd_type  cmd,
   output ntcp_stat_type stat
);

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = $clog2(STORE_DEPTH + 1);

   ntcp_req_type      req_ff;
   logic [3:0]        phase_ff, phase_in;
   logic [2:0]        name_ff, name_in;
   logic signed [9:0] pitch_ff, pitch_in;
   logic [7:0]        acc_char_ff, acc_char_in;
   logic [1:0]        acc_cnt_ff, acc_cnt_in;
   logic              coh_ff, coh_in;
   logic              wp_ff, wp_in;
   logic              hold_ff, hold_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [1:0]        last_dur_ff, last_dur_in;

   logic [1:0]        nres_in;
   ntcp_rsp_type      res_in;
   logic              we_in;
   logic [7:0]        wbyte_in;
   logic [AW-1:0]     wa_in;

   logic [7:0]        c;
   logic [2:0]        d;
   logic signed [15:0] octv, idx;
   logic [7:0]        dot_byte;
   logic [7:0]        emit_pitch;

   logic [7:0]        mem [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [AW-1:0]     s_ff, s_in;
   logic [7:0]        b_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [7:0]        mem_wd;

   logic [AW+7:0]     pos_wide, s_wide;
   logic [AW-1:0]     pos_addr;
   logic [CW+8:0]     cnt_wide;

   logic              rsp_valid_ff;
   ntcp_rsp_type      rsp_data_ff, out_in;
   logic              out_load;

   assign c = req_ff.ch;
   assign d = dur_code(c);
   assign octv = $signed({8'd0, c}) - 16'sd49 - $signed({15'd0, coh_ff});
   assign idx = $signed({{6{pitch_ff[9]}}, pitch_ff}) + (octv <<< 5) + (octv <<< 4);

   always_comb begin
      phase_in    = phase_ff;
      name_in     = name_ff;
      pitch_in    = pitch_ff;
      acc_char_in = acc_char_ff;
      acc_cnt_in  = acc_cnt_ff;
      coh_in      = coh_ff;
      wp_in       = wp_ff;
      hold_in     = hold_ff;
      count_in    = count_ff;
      last_dur_in = last_dur_ff;
      nres_in     = 2'd0;
      we_in       = 1'b0;
      wbyte_in    = 8'd0;
      wa_in       = count_ff[AW-1:0];
      res_in      = '0;
      res_in.kind = KIND_CODE;
      res_in.error_code = ERR_NONE;
      dot_byte    = {6'd0, last_dur_ff} - 8'd1 + {7'd0, wp_ff};
      emit_pitch  = (phase_ff == PH_TIE) ? 8'd0 : (pitch_ff[7:0] & 8'hFC);

      if (hold_ff) begin
         if (c == CH_NUL) begin
            hold_in  = 1'b0;
            phase_in = PH_DONE;
         end
      end else begin
         // new string: drop the previous count first
         if (phase_ff == PH_DONE) begin
            count_in = '0;
            wp_in    = 1'b0;
            phase_in = PH_START;
         end
         wa_in = count_in[AW-1:0];
         case (phase_in)
            PH_START: begin
               if (c == CH_SPACE && count_in != '0) begin
                  nres_in = 2'd0;
               end else if (c == CH_NUL) begin
                  phase_in    = PH_DONE;
                  nres_in     = 2'd1;
                  res_in.kind = KIND_ACCEPT;
               end else if (count_in >= CW'(STORE_DEPTH)) begin
                  nres_in = 2'd1; hold_in = 1'b1;
                  res_in.kind = KIND_ERROR; res_in.error_code = ERR_TOO_LONG;
               end else if (c == CH_TIE) begin
                  if (count_in == '0) begin
                     nres_in = 2'd1; hold_in = 1'b1;
                     res_in.kind = KIND_ERROR; res_in.error_code = ERR_TIE_FIRST;
                  end else begin
                     phase_in = PH_TIE;
                  end
               end else if (c == CH_DOT) begin
                  if (count_in == '0) begin
                     nres_in = 2'd1; hold_in = 1'b1;
                     res_in.kind = KIND_ERROR; res_in.error_code = ERR_DOT_FIRST;
                  end else if (last_dur_ff == 2'd0) begin
                     nres_in = 2'd1; hold_in = 1'b1;
                     res_in.kind = KIND_ERROR; res_in.error_code = ERR_DOT_SIX;
                  end else begin
                     wp_in    = 1'b0;
                     we_in    = 1'b1;
                     wbyte_in = dot_byte;
                     count_in = count_in + CW'(1);
                     last_dur_in = dot_byte[1:0];
                     nres_in  = 2'd1;
                     res_in.code_byte = dot_byte;
                  end
               end else begin
                  phase_in = PH_NAME2;
                  case (c)
                     8'h73:   name_in = 3'd0;
                     8'h6C:   name_in = 3'd1;
                     8'h64:   name_in = 3'd3;
                     8'h72:   name_in = 3'd4;
                     8'h6D:   name_in = 3'd5;
                     8'h66:   name_in = 3'd6;
                     default: begin
                        phase_in = phase_ff == PH_DONE ? PH_START : phase_ff;
                        nres_in = 2'd1; hold_in = 1'b1;
                        res_in.kind = KIND_ERROR; res_in.error_code = ERR_BAD_NAME;
                     end
                  endcase
               end
            end
            PH_NAME2, PH_NAME3: begin
               if (phase_ff == PH_NAME2 && name_ff == 3'd0 && c == 8'h6F) begin
                  phase_in = PH_NAME3;
               end else if ((phase_ff == PH_NAME2 && name_ff == 3'd0 && c == 8'h69) ||
                            (phase_ff == PH_NAME2 && name_ff != 3'd0 &&
                             c == second_char(name_ff)) ||
                            (phase_ff == PH_NAME3 && c == 8'h6C)) begin
                  name_in = (phase_ff == PH_NAME3) ? 3'd0 :
                            (name_ff == 3'd0) ? 3'd2 : name_ff;
                  pitch_in    = name_base(name_in);
                  coh_in      = (name_in >= 3'd3);
                  acc_cnt_in  = 2'd0;
                  acc_char_in = 8'd0;
                  phase_in    = PH_ACC;
               end else begin
                  nres_in = 2'd1; hold_in = 1'b1;
                  res_in.kind = KIND_ERROR; res_in.error_code = ERR_BAD_NAME;
               end
            end
            PH_ACC: begin
               if (acc_cnt_ff == 2'd0 && (c == CH_HASH || c == CH_FLAT)) begin
                  acc_char_in = c;
                  acc_cnt_in  = 2'd1;
                  pitch_in    = pitch_ff + ((c == CH_HASH) ? 10'sd4 : -10'sd4);
               end else if (acc_cnt_ff == 2'd1 && c == acc_char_ff) begin
                  acc_cnt_in = 2'd2;
                  pitch_in   = pitch_ff + ((c == CH_HASH) ? 10'sd4 : -10'sd4);
               end else if (idx < 16'sd4 || idx > 16'sd255) begin
                  nres_in = 2'd1; hold_in = 1'b1;
                  res_in.kind = KIND_ERROR; res_in.error_code = ERR_PITCH;
               end else begin
                  pitch_in = idx[9:0];
                  phase_in = PH_DUR;
               end
            end
            PH_DUR, PH_TIE: begin
               if (d == DUR_BAD) begin
                  nres_in = 2'd1; hold_in = 1'b1;
                  res_in.kind = KIND_ERROR; res_in.error_code = ERR_BAD_DUR;
               end else begin
                  phase_in = PH_START;
                  if (d == DUR_WHOLE) begin
                     if ({1'b0, count_in} + (CW+1)'(2) > (CW+1)'(STORE_DEPTH)) begin
                        nres_in = 2'd1; hold_in = 1'b1;
                        res_in.kind = KIND_ERROR; res_in.error_code = ERR_TOO_LONG;
                     end else begin
                        wp_in    = 1'b1;
                        we_in    = 1'b1;
                        wbyte_in = emit_pitch | 8'd3;
                        count_in = count_in + CW'(1);
                        last_dur_in = 2'd3;
                        nres_in  = 2'd2;
                        res_in.code_byte = emit_pitch | 8'd3;
                     end
                  end else begin
                     wp_in    = 1'b0;
                     we_in    = 1'b1;
                     wbyte_in = emit_pitch | {6'd0, d[1:0]};
                     count_in = count_in + CW'(1);
                     last_dur_in = d[1:0];
                     nres_in  = 2'd1;
                     res_in.code_byte = emit_pitch | {6'd0, d[1:0]};
                  end
               end
            end
            default: phase_in = PH_START;
         endcase
         if (c == CH_NUL) begin
            hold_in  = 1'b0;
            phase_in = PH_DONE;
         end
      end
      cnt_wide = {9'd0, count_in};
      res_in.stored_count = cnt_wide[8:0];
      res_in.last = (nres_in == 2'd1);
   end

   // query addressing
   assign pos_wide = {{AW{1'b0}}, req_ff.query_pos};
   assign pos_addr = pos_wide[AW-1:0];
   assign s_wide   = {8'd0, s_ff};

   always_comb begin
      s_in = s_ff;
      if (cmd.q_start) begin
         s_in = pos_addr;
      end else if (cmd.q_step) begin
         s_in = s_ff - AW'(1);
      end
   end

   assign mem_we = (cmd.char_commit && we_in) || cmd.second;
   assign mem_wa = cmd.second ? count_ff[AW-1:0] : wa_in;
   assign mem_wd = cmd.second ? 8'd3 : wbyte_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[s_in];
   end

   // result word
   always_comb begin
      logic [CW+8:0] cw;
      cw       = {9'd0, count_ff};
      out_in   = res_in;
      out_load = 1'b0;
      if (cmd.char_commit) begin
         out_load = (nres_in != 2'd0);
      end else if (cmd.second) begin
         cw = {9'd0, count_ff} + (CW+9)'(1);
         out_in = '0;
         out_in.kind = KIND_CODE;
         out_in.code_byte = 8'd3;
         out_in.error_code = ERR_NONE;
         out_in.stored_count = cw[8:0];
         out_in.last = 1'b1;
         out_load = 1'b1;
      end else if (cmd.q_load) begin
         out_in = '0;
         out_in.kind = KIND_QUERY;
         out_in.error_code = ERR_NONE;
         out_in.stored_count = cw[8:0];
         out_in.last = 1'b1;
         if (stat.past_end) begin
            out_in.start_pos = req_ff.query_pos;
         end else begin
            out_in.duration_sixteenths = 4'd1 << b_ff[1:0];
            out_in.midi_pitch = (b_ff[7:2] == 6'd0) ? 7'd0 :
                                7'({1'b0, b_ff[7:2]} + MIDI_OFFSET[6:0]);
            out_in.start_pos = s_wide[7:0];
         end
         out_load = 1'b1;
      end
   end

   assign stat.in_query  = (req_data.req_type == REQ_QUERY);
   assign stat.nres      = nres_in;
   assign stat.past_end  = ({{CW{1'b0}}, req_ff.query_pos} >= {8'd0, count_ff});
   assign stat.walk_done = (s_ff == '0) || (rd_data_ff[7:2] != 6'd0);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.q_capture) begin
         b_ff <= rd_data_ff;
      end
      s_ff <= s_in;
      if (out_load) begin
         rsp_data_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         name_ff      <= 3'd0;
         pitch_ff     <= 10'sd0;
         acc_char_ff  <= 8'd0;
         acc_cnt_ff   <= 2'd0;
         coh_ff       <= 1'b0;
         wp_ff        <= 1'b0;
         hold_ff      <= 1'b0;
         count_ff     <= '0;
         last_dur_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.char_commit) begin
            phase_ff    <= phase_in;
            name_ff     <= name_in;
            pitch_ff    <= pitch_in;
            acc_char_ff <= acc_char_in;
            acc_cnt_ff  <= acc_cnt_in;
            coh_ff      <= coh_in;
            wp_ff       <= wp_in;
            hold_ff     <= hold_in;
            count_ff    <= count_in;
            last_dur_ff <= last_dur_in;
         end else if (cmd.second) begin
            count_ff    <= count_ff + CW'(1);
            last_dur_ff <= 2'd3;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

[design/note_text_to_code_parser.sv]
// ----------------------------------------------------------------------------
// note_text_to_code_parser
// Parses note text one character per word into stored code bytes and answers
// position queries from the store.
//
//   channel   direction   word type        handshake
//   req_      in          ntcp_req_type    req_valid / req_stall
//   rsp_      out         ntcp_rsp_type    rsp_valid / rsp_stall
//
// A whole note gives two result words. A query past the end is answered
// without a walk; otherwise the store is walked back over pitchless bytes, one
// store read per cycle. Reset is synchronous and clears the sequencer,
// parser state, the stored count and the result valid flag, not the store.
// The result register takes a new word while the old one drains; a stalled
// result holds the sequencer before it loads the next result word.
// ----------------------------------------------------------------------------
module note_text_to_code_parser
   import ntcp_pkg::*;
#(
   parameter int STORE_DEPTH = 256
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ntcp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ntcp_rsp_type rsp_data
);

   ntcp_cmd_type  cmd;
   ntcp_stat_type stat;

   ntcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ntcp_dp #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

[design/ntcp_chk.sv]
// ----------------------------------------------------------------------------
// ntcp_chk
// Port checks for the note text parser, bound to the top level.
// ----------------------------------------------------------------------------
module ntcp_chk
   import ntcp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input ntcp_rsp_type rsp_data
);

   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input word accepted while a word is in flight");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result valid or input stalled after reset");

   a_query_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_QUERY |->
         rsp_data.duration_sixteenths == 4'd0 && rsp_data.midi_pitch == 7'd0 &&
         rsp_data.start_pos == 8'd0)
      else $error("query fields set on a non-query word");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_ERROR |-> rsp_data.error_code != ERR_NONE)
      else $error("error word without an error code");

endmodule

bind note_text_to_code_parser ntcp_chk u_chk (.*);

[test/note_text_to_code_parser_tb.sv]
// ----------------------------------------------------------------------------
// note_text_to_code_parser_tb
// Drives note text and position queries into the parser with random idling
// on both channels, predicts every result word and checks them in order.
// ----------------------------------------------------------------------------
module note_text_to_code_parser_tb;
   import ntcp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 256;
   localparam int LIMIT = 2000000;

   class note_scoreboard;
      logic [3:0]  phase;
      logic [2:0]  nidx;
      int          pitch;
      logic [7:0]  acc_ch;
      int          acc_n;
      bit          c_hi;
      bit          whole_pend;
      bit          err_hold;
      int          count;
      logic [7:0]  store [DEPTH];
      ntcp_rsp_type expected [$];
      int          errors;
      int          checked;

      function new();
         phase = PH_START; nidx = 0; pitch = 0; acc_ch = 0; acc_n = 0;
         c_hi = 0; whole_pend = 0; err_hold = 0; count = 0; errors = 0;
         checked = 0;
      endfunction

      function void push(logic [1:0] kind, logic [7:0] code, logic [2:0] err,
                         logic [3:0] dur, logic [6:0] midi, logic [7:0] st);
         ntcp_rsp_type r;
         r.kind = kind; r.code_byte = code; r.error_code = err;
         r.stored_count = count[8:0]; r.duration_sixteenths = dur;
         r.midi_pitch = midi; r.start_pos = st; r.last = 1'b0;
         expected.push_back(r);
      endfunction

      function void raise(logic [2:0] code);
         err_hold = 1;
         push(KIND_ERROR, 8'd0, code, 4'd0, 7'd0, 8'd0);
      endfunction

      function void store_code(logic [7:0] b);
         if (count < DEPTH) begin
            store[count] = b;
            count++;
         end
         push(KIND_CODE, b, ERR_NONE, 4'd0, 7'd0, 8'd0);
      endfunction

      function void name_done(int n);
         pitch = (1 + 2 * n - (n > 2) - (n == 6)) * 4;
         c_hi = pitch > 20;
         nidx = n[2:0];
         acc_n = 0;
         acc_ch = 0;
         phase = PH_ACC;
      endfunction

      function void emit(logic [7:0] c, logic [7:0] p);
         int d;
         case (c)
            "s": d = 0;
            "c": d = 1;
            "n": d = 2;
            "b": d = 3;
            "r": d = 4;
            default: d = -1;
         endcase
         if (d < 0) begin
            raise(ERR_BAD_DUR);
            return;
         end
         phase = PH_START;
         if (d == 4) begin
            if (count + 2 > DEPTH) begin
               raise(ERR_TOO_LONG);
               return;
            end
            whole_pend = 1;
            store_code(p | 8'd3);
            store_code(8'd3);
         end else begin
            whole_pend = 0;
            store_code(p | d[7:0]);
         end
      endfunction

      function void parse_char(logic [7:0] c);
         int idx;
         logic [7:0] b;
         if (err_hold) begin
            if (c == CH_NUL) begin
               err_hold = 0;
               phase = PH_DONE;
            end
            return;
         end
         if (phase == PH_DONE) begin
            count = 0;
            whole_pend = 0;
            phase = PH_START;
         end
         case (phase)
            PH_START: begin
               if (c == CH_SPACE && count > 0) return;
               if (c == CH_NUL) begin
                  phase = PH_DONE;
                  push(KIND_ACCEPT, 8'd0, ERR_NONE, 4'd0, 7'd0, 8'd0);
                  return;
               end
               if (count >= DEPTH) begin
                  raise(ERR_TOO_LONG);
                  return;
               end
               if (c == CH_TIE) begin
                  if (count == 0) raise(ERR_TIE_FIRST);
                  else phase = PH_TIE;
                  return;
               end
               if (c == CH_DOT) begin
                  if (count == 0) begin
                     raise(ERR_DOT_FIRST);
                     return;
                  end
                  b = store[count - 1] & 8'd3;
                  if (b == 0) begin
                     raise(ERR_DOT_SIX);
                     return;
                  end
                  if (whole_pend) b++;
                  whole_pend = 0;
                  store_code(b - 8'd1);
                  return;
               end
               case (c)
                  "s": nidx = 0;
                  "l": nidx = 1;
                  "d": nidx = 3;
                  "r": nidx = 4;
                  "m": nidx = 5;
                  "f": nidx = 6;
                  default: begin
                     raise(ERR_BAD_NAME);
                     return;
                  end
               endcase
               phase = PH_NAME2;
               return;
            end
            PH_NAME2: begin
               if (nidx == 0) begin
                  if (c == "o") phase = PH_NAME3;
                  else if (c == "i") name_done(2);
                  else raise(ERR_BAD_NAME);
               end else if (c == second_char(nidx)) begin
                  name_done(nidx);
               end else begin
                  raise(ERR_BAD_NAME);
               end
            end
            PH_NAME3: begin
               if (c == "l") name_done(0);
               else raise(ERR_BAD_NAME);
            end
            PH_ACC: begin
               if (acc_n == 0 && (c == CH_HASH || c == CH_FLAT)) begin
                  acc_ch = c;
                  acc_n = 1;
                  pitch += (c == CH_HASH) ? 4 : -4;
               end else if (acc_n == 1 && c == acc_ch) begin
                  acc_n = 2;
                  pitch += (c == CH_HASH) ? 4 : -4;
               end else begin
                  idx = pitch + 48 * (int'(c) - 49 - int'(c_hi));
                  if (idx < 4 || idx > 255) raise(ERR_PITCH);
                  else begin
                     pitch = idx;
                     phase = PH_DUR;
                  end
               end
            end
            PH_DUR: emit(c, pitch[7:0] & 8'hFC);
            PH_TIE: emit(c, 8'd0);
            default: phase = PH_START;
         endcase
         if (c == CH_NUL) begin
            err_hold = 0;
            phase = PH_DONE;
         end
      endfunction

      // note an accepted input word and queue what it should produce
      function void note_input(ntcp_req_type w);
         int n_before, s;
         logic [7:0] b;
         n_before = expected.size();
         if (w.req_type == REQ_QUERY) begin
            if (w.query_pos >= count) begin
               push(KIND_QUERY, 8'd0, ERR_NONE, 4'd0, 7'd0, w.query_pos);
            end else begin
               b = store[w.query_pos];
               s = w.query_pos;
               while (s > 0 && store[s][7:2] == 0) s--;
               push(KIND_QUERY, 8'd0, ERR_NONE, 4'd1 << b[1:0],
                    (b < 4) ? 7'd0 : 7'(b[7:2] + 30), s[7:0]);
            end
         end else begin
            parse_char(w.ch);
         end
         if (expected.size() > n_before) expected[$].last = 1'b1;
      endfunction

      function void check_result(ntcp_rsp_type got);
         ntcp_rsp_type e;
         if (expected.size() == 0) begin
            $error("unexpected result word %h", got);
            errors++;
            return;
         end
         e = expected.pop_front();
         checked++;
         if (got.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, got.kind); errors++;
         end
         if (got.code_byte !== e.code_byte) begin
            $error("code_byte exp %h got %h", e.code_byte, got.code_byte); errors++;
         end
         if (got.error_code !== e.error_code) begin
            $error("error_code exp %0d got %0d", e.error_code, got.error_code);
            errors++;
         end
         if (got.stored_count !== e.stored_count) begin
            $error("stored_count exp %0d got %0d", e.stored_count, got.stored_count);
            errors++;
         end
         if (got.duration_sixteenths !== e.duration_sixteenths) begin
            $error("duration_sixteenths exp %0d got %0d", e.duration_sixteenths,
                   got.duration_sixteenths);
            errors++;
         end
         if (got.midi_pitch !== e.midi_pitch) begin
            $error("midi_pitch exp %0d got %0d", e.midi_pitch, got.midi_pitch);
            errors++;
         end
         if (got.start_pos !== e.start_pos) begin
            $error("start_pos exp %0d got %0d", e.start_pos, got.start_pos);
            errors++;
         end
         if (got.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, got.last); errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   ntcp_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   ntcp_rsp_type rsp_data;

   note_scoreboard board = new();
   int  cycles = 0;
   bit  idle_on = 1'b1;
   bit  long_hold = 1'b0;
   int  sent = 0;
   int  chars_sent = 0;
   int  queries_sent = 0;

   always #1 clock = ~clock;

   note_text_to_code_parser u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: check on accept, stall in bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   initial begin : receiver
      int n;
      @(posedge clock);
      while (1) begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < 300; n++) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
      end
   end

   task automatic send_word(ntcp_req_type w);
      int gap;
      if (idle_on && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 17);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_input(w);
      sent++;
      if (w.req_type == REQ_QUERY) queries_sent++;
      else chars_sent++;
   endtask

   task automatic send_char(logic [7:0] c);
      ntcp_req_type w;
      w.req_type = REQ_CHAR;
      w.ch = c;
      w.query_pos = 8'($urandom);
      send_word(w);
   endtask

   task automatic send_query(logic [7:0] p);
      ntcp_req_type w;
      w.req_type = REQ_QUERY;
      w.ch = 8'($urandom);
      w.query_pos = p;
      send_word(w);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // one token with random content: a tie and duration, a dot, or a named note
   task automatic send_token();
      string names [7] = '{"sol", "la", "si", "do", "re", "mi", "fa"};
      string durs = "scnbr";
      int k, a;
      k = $urandom_range(0, 9);
      if (k == 0) begin
         send_char(CH_TIE);
         send_char(durs[$urandom_range(0, 4)]);
      end else if (k == 1) begin
         send_char(CH_DOT);
      end else begin
         send_text(names[$urandom_range(0, 6)]);
         a = $urandom_range(0, 2);
         repeat (a) send_char((k & 1) ? CH_HASH : CH_FLAT);
         send_char(8'($urandom_range(49, 54)));
         send_char(durs[$urandom_range(0, 4)]);
      end
      if ($urandom_range(0, 3) == 0) send_char(CH_SPACE);
   endtask

   initial begin : stimulus
      int i, len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every name, accidentals, ties, dots, whole notes, errors
      send_text("sol1sla#2cdobb3nre4bmi5r.fa1s_n.");
      send_query(8'd0); send_query(8'd7); send_query(8'd9); send_query(8'd255);
      send_char(CH_NUL);
      send_char(CH_SPACE); send_char(CH_NUL);        // leading space
      send_char(CH_TIE); send_char(CH_NUL);          // tie first
      send_char(CH_DOT); send_char(CH_NUL);          // dot first
      send_text("do1s."); send_char(CH_NUL);         // dot on sixteenth
      send_text("sol0s"); send_char(CH_NUL);         // pitch range low
      send_text("si\xffs"); send_char(CH_NUL);       // pitch range high
      send_text("la3x"); send_char(CH_NUL);          // bad duration
      send_text("so"); send_char(CH_NUL);            // terminator in token
      send_text("qz"); send_char(CH_NUL);            // bad name
      send_char(CH_NUL);
      drain();

      // fill the store: too long on plain and whole notes
      send_text("re3s");
      for (i = 0; i < 127; i++) send_text("_r");
      send_text("_r");
      send_char(CH_NUL);
      send_text("re3s");
      for (i = 0; i < 127; i++) send_text("_r");
      send_char(CH_DOT);
      send_query(8'd254); send_query(8'd255);
      send_text("fa2c");
      send_text("la1s"); send_char(CH_NUL);
      drain();

      // long receiver hold while words keep coming
      long_hold = 1'b1;
      for (i = 0; i < 20; i++) send_token();
      drain();

      while (sent < 1200) begin
         if (sent > 1050) idle_on = 1'b0;
         len = $urandom_range(1, 12);
         for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_char(8'($urandom));
            else if ($urandom_range(0, 5) == 0) send_query(8'($urandom_range(0, 20)));
            else send_token();
         end
         if ($urandom_range(0, 4) == 0) send_query(8'($urandom));
         send_char(CH_NUL);
      end
      drain();
      repeat (50) @(posedge clock);

      $display("%0d words sent (%0d characters, %0d queries), %0d results checked",
               sent, chars_sent, queries_sent, board.checked);
      if (board.errors == 0 && board.expected.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
design/ntcp_pkg.sv
design/ntcp_ctrl.sv
design/ntcp_dp.sv
design/note_text_to_code_parser.sv
design/ntcp_chk.sv
test/note_text_to_code_parser_tb.sv
